[rtl/core/hea_pkg.sv]
// ----------------------------------------------------------------------------
// hea_pkg
// Shared types, codes and constants of the Hermite expansion accumulator.
// ----------------------------------------------------------------------------
package hea_pkg;

    localparam int DEF_MAX_ORDER = 7;
    localparam int MAX_LEVEL     = 20;
    // Wide enough for a term index at the largest supported order (15).
    localparam int KW            = 4;

    localparam logic signed [63:0] Q32_ONE = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_LEVEL    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    // Operand pairs fed to the shared multiplier.
    typedef enum logic [2:0] {
        OP_PW_D = 3'd0,  // previous power * offset
        OP_PW_R = 3'd1,  // product * 1/k
        OP_T_XY = 3'd2,  // px * py
        OP_T_Z  = 3'd3,  // product * pz
        OP_T_S  = 3'd4   // product * strength
    } op_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic signed [31:0] src_z;
        logic signed [31:0] strength;
        logic [8:0]         coeff_index;
    } req_t;

    typedef struct packed {
        logic signed [63:0] coeff_value;
        logic               saturated;
    } rsp_t;

    typedef struct packed {
        logic          latch;
        logic          setup;
        logic          prev_init;
        axis_t         axis;
        logic          mul_start;
        op_t           op;
        logic          pw_store;
        logic [KW-1:0] k;
        logic [KW-1:0] j;
        logic [KW-1:0] v;
        logic          ram_rd;
        logic          acc_wr;
        logic          clr_wr;
        logic          rd_sel;
    } ctl_t;

    typedef struct packed {
        logic mul_done;
    } sts_t;

    // Q32.32 reciprocals of k.
    function automatic logic signed [63:0] recip(input logic [3:0] k);
        logic signed [63:0] r;
        case (k)
            4'd1:    r = 64'sd4294967296;
            4'd2:    r = 64'sd2147483648;
            4'd3:    r = 64'sd1431655765;
            4'd4:    r = 64'sd1073741824;
            4'd5:    r = 64'sd858993459;
            4'd6:    r = 64'sd715827883;
            4'd7:    r = 64'sd613566757;
            4'd8:    r = 64'sd536870912;
            4'd9:    r = 64'sd477218588;
            4'd10:   r = 64'sd429496730;
            4'd11:   r = 64'sd390451572;
            4'd12:   r = 64'sd357913941;
            4'd13:   r = 64'sd330382100;
            4'd14:   r = 64'sd306783378;
            4'd15:   r = 64'sd286331153;
            default: r = 64'sd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/hea_ram.sv]
// ----------------------------------------------------------------------------
// hea_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module hea_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/hea_qmul.sv]
// ----------------------------------------------------------------------------
// hea_qmul
// Q32.32 multiplier: four 32x32 partial products accumulated in turn, then
// round half away from zero and saturate. Result held until the next one.
// ----------------------------------------------------------------------------
module hea_qmul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] res,
    output logic               sat
);

    import hea_pkg::*;

    logic         neg_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic [127:0] acc_reg;
    logic [2:0]   ph_reg;
    logic         run_reg;
    logic         done_reg;
    logic signed [63:0] res_reg;
    logic         sat_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [6:0]   shamt;
    logic [63:0]  r;
    logic [63:0]  lim;
    logic         over;

    always_comb
    begin
        a_half = ph_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_half = ph_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp     = a_half * b_half;
        case (ph_reg[1:0])
            2'd0:    shamt = 7'd0;
            2'd3:    shamt = 7'd64;
            default: shamt = 7'd32;
        endcase
        r    = acc_reg[95:32];
        lim  = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        over = (|acc_reg[127:96]) || (r > lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                ph_reg  <= 3'd0;
            end
            else if (run_reg)
            begin
                if (ph_reg == 3'd5)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                ph_reg <= ph_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[63] ^ b[63];
            ua_reg  <= a[63] ? 64'(-a) : a;
            ub_reg  <= b[63] ? 64'(-b) : b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (ph_reg < 3'd4)
            begin
                acc_reg <= acc_reg + (128'(pp) << shamt);
            end
            else if (ph_reg == 3'd4)
            begin
                acc_reg <= acc_reg + 128'h8000_0000;
            end
            else
            begin
                sat_reg <= over;
                if (over)
                begin
                    res_reg <= neg_reg ? Q64_MIN : Q64_MAX;
                end
                else
                begin
                    res_reg <= neg_reg ? 64'(-r) : r;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign sat  = sat_reg;

endmodule

[rtl/core/hea_dp.sv]
// ----------------------------------------------------------------------------
// hea_dp
// Datapath: config registers, scaled offsets, power tables, shared Q32.32
// multiplier, saturating accumulate and the coefficient store.
// ----------------------------------------------------------------------------
module hea_dp #(
    parameter int MAX_ORDER = hea_pkg::DEF_MAX_ORDER
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_idx,
    input  logic [31:0]   cfg_wdata,
    input  hea_pkg::req_t req,
    input  hea_pkg::ctl_t ctl,
    input  logic [$clog2((MAX_ORDER+1)**3)-1:0] addr,
    output hea_pkg::sts_t sts,
    output hea_pkg::rsp_t rsp
);

    import hea_pkg::*;

    localparam int NTERM = MAX_ORDER + 1;
    localparam int DEPTH = NTERM * NTERM * NTERM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(NTERM);

    logic signed [31:0] cen_x_reg, cen_y_reg, cen_z_reg;
    logic [4:0]         level_reg;
    req_t               in_reg;

    logic signed [63:0] d_reg [3];
    logic signed [63:0] px_reg [NTERM];
    logic signed [63:0] py_reg [NTERM];
    logic signed [63:0] pz_reg [NTERM];
    logic               sx_reg [NTERM];
    logic               sy_reg [NTERM];
    logic               sz_reg [NTERM];
    logic signed [63:0] prev_reg;
    logic               prev_sat_reg;
    logic               csat_reg;

    logic [IW-1:0]      ki, ji, vi;
    logic [4:0]         lev;
    logic [4:0]         sh;
    logic signed [63:0] st;
    logic signed [63:0] dx, dy, dz;
    logic signed [63:0] opa, opb;
    logic signed [63:0] d_sel;
    logic               q_done, q_sat;
    logic signed [63:0] q_res;
    logic [64:0]        ram_rdata;
    logic [64:0]        ram_wdata;
    logic [AW-1:0]      ram_addr;
    logic [64:0]        sum;
    logic               add_ovf;
    logic signed [63:0] acc_val;
    logic               in_range;

    function automatic logic signed [63:0] scaled_diff(input logic signed [31:0] s,
                                                       input logic signed [31:0] c,
                                                       input logic [4:0] n);
        logic signed [32:0] df;
        df = 33'(s) - 33'(c);
        return 64'(df) <<< n;
    endfunction

    always_comb
    begin
        ki  = ctl.k[IW-1:0];
        ji  = ctl.j[IW-1:0];
        vi  = ctl.v[IW-1:0];
        lev = (level_reg > 5'(MAX_LEVEL)) ? 5'(MAX_LEVEL) : level_reg;
        sh  = lev + 5'd2;
        st  = {{16{in_reg.strength[31]}}, in_reg.strength, 16'h0000};
        dx  = scaled_diff(in_reg.src_x, cen_x_reg, sh);
        dy  = scaled_diff(in_reg.src_y, cen_y_reg, sh);
        dz  = scaled_diff(in_reg.src_z, cen_z_reg, sh);
        case (ctl.axis)
            AX_Y:    d_sel = d_reg[1];
            AX_Z:    d_sel = d_reg[2];
            default: d_sel = d_reg[0];
        endcase
        case (ctl.op)
            OP_PW_D:
            begin
                opa = prev_reg;
                opb = d_sel;
            end
            OP_PW_R:
            begin
                opa = q_res;
                opb = recip(ctl.k);
            end
            OP_T_XY:
            begin
                opa = px_reg[ki];
                opb = py_reg[ji];
            end
            OP_T_Z:
            begin
                opa = q_res;
                opb = pz_reg[vi];
            end
            OP_T_S:
            begin
                opa = q_res;
                opb = st;
            end
            default:
            begin
                opa = q_res;
                opb = st;
            end
        endcase
        sum     = {ram_rdata[63], ram_rdata[63:0]} + {q_res[63], q_res};
        add_ovf = sum[64] ^ sum[63];
        acc_val = add_ovf ? (sum[64] ? Q64_MIN : Q64_MAX) : sum[63:0];
        ram_addr = ctl.rd_sel ? AW'(in_reg.coeff_index) : addr;
        if (ctl.clr_wr)
        begin
            ram_wdata = '0;
        end
        else
        begin
            ram_wdata = {ram_rdata[64] | csat_reg | add_ovf, acc_val};
        end
        in_range = 32'(in_reg.coeff_index) < 32'(DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_x_reg <= '0;
            cen_y_reg <= '0;
            cen_z_reg <= '0;
            level_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_CENTER_X: cen_x_reg <= cfg_wdata;
                CFG_CENTER_Y: cen_y_reg <= cfg_wdata;
                CFG_CENTER_Z: cen_z_reg <= cfg_wdata;
                CFG_LEVEL:    level_reg <= cfg_wdata[4:0];
                default:      level_reg <= level_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            in_reg <= req;
        end
        if (ctl.setup)
        begin
            d_reg[0]  <= dx;
            d_reg[1]  <= dy;
            d_reg[2]  <= dz;
            px_reg[0] <= Q32_ONE;
            py_reg[0] <= Q32_ONE;
            pz_reg[0] <= Q32_ONE;
            sx_reg[0] <= 1'b0;
            sy_reg[0] <= 1'b0;
            sz_reg[0] <= 1'b0;
        end
        if (ctl.pw_store)
        begin
            case (ctl.axis)
                AX_Y:
                begin
                    py_reg[ki] <= q_res;
                    sy_reg[ki] <= csat_reg;
                end
                AX_Z:
                begin
                    pz_reg[ki] <= q_res;
                    sz_reg[ki] <= csat_reg;
                end
                default:
                begin
                    px_reg[ki] <= q_res;
                    sx_reg[ki] <= csat_reg;
                end
            endcase
        end
        // new axis restarts the chain at 1.0
        if (ctl.prev_init)
        begin
            prev_reg     <= Q32_ONE;
            prev_sat_reg <= 1'b0;
        end
        else if (ctl.pw_store)
        begin
            prev_reg     <= q_res;
            prev_sat_reg <= csat_reg;
        end
        if (ctl.mul_start && ctl.op == OP_PW_D)
        begin
            csat_reg <= prev_sat_reg;
        end
        else if (ctl.mul_start && ctl.op == OP_T_XY)
        begin
            csat_reg <= sx_reg[ki] | sy_reg[ji] | sz_reg[vi];
        end
        else if (q_done)
        begin
            csat_reg <= csat_reg | q_sat;
        end
    end

    hea_qmul u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.mul_start),
        .a     (opa),
        .b     (opb),
        .done  (q_done),
        .res   (q_res),
        .sat   (q_sat)
    );

    hea_ram #(
        .WIDTH (65),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctl.acc_wr | ctl.clr_wr),
        .re    (ctl.ram_rd),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign sts.mul_done    = q_done;
    assign rsp.coeff_value = in_range ? ram_rdata[63:0] : '0;
    assign rsp.saturated   = in_range ? ram_rdata[64] : 1'b0;

endmodule

[rtl/core/hea_ctrl.sv]
// ----------------------------------------------------------------------------
// hea_ctrl
// Sequencer: store clearing sweep, power chains per axis, per-coefficient
// multiply-accumulate loop and coefficient reads.
// ----------------------------------------------------------------------------
module hea_ctrl #(
    parameter int MAX_ORDER = hea_pkg::DEF_MAX_ORDER
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    cmd,
    input  hea_pkg::sts_t sts,
    output hea_pkg::ctl_t ctl,
    output logic [$clog2((MAX_ORDER+1)**3)-1:0] addr,
    output logic          busy,
    output logic          valid
);

    import hea_pkg::*;

    localparam int NTERM = MAX_ORDER + 1;
    localparam int DEPTH = NTERM * NTERM * NTERM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(NTERM);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_CLR   = 17'h00002,
        S_SETUP = 17'h00004,
        S_PW1   = 17'h00008,
        S_PW1W  = 17'h00010,
        S_PW2   = 17'h00020,
        S_PW2W  = 17'h00040,
        S_PST   = 17'h00080,
        S_T1    = 17'h00100,
        S_T1W   = 17'h00200,
        S_T2    = 17'h00400,
        S_T2W   = 17'h00800,
        S_T3    = 17'h01000,
        S_T3W   = 17'h02000,
        S_ACC   = 17'h04000,
        S_READ  = 17'h08000,
        S_RESP  = 17'h10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] v_reg, v_next;
    axis_t         axis_reg, axis_next;

    logic          idx_last;
    logic          k_last;
    logic          j_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            v_reg     <= '0;
            axis_reg  <= AX_X;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            v_reg     <= v_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        idx_last   = idx_reg == AW'(DEPTH - 1);
        k_last     = k_reg == IW'(MAX_ORDER);
        j_last     = j_reg == IW'(MAX_ORDER);
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        v_next     = v_reg;
        axis_next  = axis_reg;
        ctl        = '0;
        ctl.axis   = axis_reg;
        ctl.k      = KW'(k_reg);
        ctl.j      = KW'(j_reg);
        ctl.v      = KW'(v_reg);
        valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch = 1'b1;
                    case (cmd)
                        CMD_ADD:   state_next = S_SETUP;
                        CMD_READ:  state_next = S_READ;
                        CMD_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = S_CLR;
                        end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLR:
            begin
                ctl.clr_wr = 1'b1;
                idx_next   = idx_reg + AW'(1);
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_SETUP:
            begin
                ctl.setup     = 1'b1;
                ctl.prev_init = 1'b1;
                axis_next     = AX_X;
                k_next        = IW'(1);
                state_next    = S_PW1;
            end
            S_PW1:
            begin
                ctl.mul_start = 1'b1;
                ctl.op        = OP_PW_D;
                state_next    = S_PW1W;
            end
            S_PW1W:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_PW2;
                end
            end
            S_PW2:
            begin
                ctl.mul_start = 1'b1;
                ctl.op        = OP_PW_R;
                state_next    = S_PW2W;
            end
            S_PW2W:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_PST;
                end
            end
            S_PST:
            begin
                ctl.pw_store = 1'b1;
                state_next   = S_PW1;
                k_next       = k_reg + IW'(1);
                if (k_last)
                begin
                    k_next = IW'(1);
                    if (axis_reg == AX_Z)
                    begin
                        k_next     = '0;
                        j_next     = '0;
                        v_next     = '0;
                        idx_next   = '0;
                        state_next = S_T1;
                    end
                    else
                    begin
                        ctl.prev_init = 1'b1;
                        axis_next     = (axis_reg == AX_X) ? AX_Y : AX_Z;
                    end
                end
            end
            S_T1:
            begin
                ctl.mul_start = 1'b1;
                ctl.op        = OP_T_XY;
                ctl.ram_rd    = 1'b1;
                state_next    = S_T1W;
            end
            S_T1W:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_T2;
                end
            end
            S_T2:
            begin
                ctl.mul_start = 1'b1;
                ctl.op        = OP_T_Z;
                state_next    = S_T2W;
            end
            S_T2W:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_T3;
                end
            end
            S_T3:
            begin
                ctl.mul_start = 1'b1;
                ctl.op        = OP_T_S;
                state_next    = S_T3W;
            end
            S_T3W:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                ctl.acc_wr = 1'b1;
                idx_next   = idx_reg + AW'(1);
                k_next     = k_reg + IW'(1);
                state_next = S_T1;
                if (k_last)
                begin
                    k_next = '0;
                    j_next = j_reg + IW'(1);
                    if (j_last)
                    begin
                        j_next = '0;
                        v_next = v_reg + IW'(1);
                    end
                end
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                ctl.rd_sel = 1'b1;
                ctl.ram_rd = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                valid      = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign addr = idx_reg;
    assign busy = state_reg != S_IDLE;

endmodule

[rtl/core/hermite_expansion_accumulator.sv]
// ----------------------------------------------------------------------------
// hermite_expansion_accumulator
// 3-D far-field Hermite expansion table with Q32.32 saturating coefficients.
// ----------------------------------------------------------------------------
// Add source: busy through the power chains and the accumulate loop; every
//   Q32.32 product runs on the one shared 32x32 multiplier.
// Read: store read in S_READ, then the result word is strobed on valid in S_RESP.
// Clear: busy while every store entry is cleared, one entry written per cycle.
// Reset: control and config registers cleared, then a clearing pass with busy high.
// The receiver cannot stall; valid is a one-cycle strobe.
module hermite_expansion_accumulator #(
    parameter int MAX_ORDER = hea_pkg::DEF_MAX_ORDER
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_idx,
    input  logic [31:0]   cfg_wdata,
    input  logic          start,
    input  hea_pkg::req_t req,
    output logic          busy,
    output logic          valid,
    output hea_pkg::rsp_t rsp
);

    import hea_pkg::*;

    localparam int DEPTH = (MAX_ORDER + 1) ** 3;
    localparam int AW    = $clog2(DEPTH);

    ctl_t          ctl;
    sts_t          sts;
    logic [AW-1:0] addr;

    hea_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (req.cmd),
        .sts   (sts),
        .ctl   (ctl),
        .addr  (addr),
        .busy  (busy),
        .valid (valid)
    );

    hea_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .ctl       (ctl),
        .addr      (addr),
        .sts       (sts),
        .rsp       (rsp)
    );

    a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe held for more than one cycle");

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result strobe while idle");

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd != CMD_NOP) |=> busy)
        else $error("accepted word did not make the block busy");

endmodule
